>>> src/wsm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the wildcard/star matcher.
// No dependencies.
package wsm_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEXT   = 2'd2,
    ACT_FINISH = 2'd3
  } action_t;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] DOT_BYTE  = 8'h2E;

  // Broadcast from the controller to every cell, qualified by the request handshake.
  typedef struct packed {
    logic       rearm;
    logic       add_token;
    logic       add_star;
    logic       text;
    logic [7:0] data;
  } cmd_t;

endpackage

>>> src/wsm_cell.sv
`timescale 1ns / 1ps
// One token position: stores the token byte, its repeat mark and the active bit.
// Depends on wsm_pkg.
module wsm_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wsm_pkg::cmd_t     cmd,
  input  logic [CNT_W-1:0]  count,
  input  logic              carry_in,
  input  logic              fwd_in,
  output logic              carry_out,
  output logic              fwd_out,
  output logic              closed
);

  localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);
  localparam logic             ARM     = 1'(IDX == 0);

  logic [7:0] char_r;
  logic       star_r;
  logic       act_r;
  logic       act_nxt;
  logic       in_use;
  logic       hit;

  assign in_use    = count > MY_POS;
  assign closed    = act_r | carry_in;
  assign carry_out = closed & star_r & in_use;
  assign hit       = closed & in_use &
                     ((char_r == wsm_pkg::DOT_BYTE) || (char_r == cmd.data));
  assign fwd_out   = hit & ~star_r;

  always_comb begin
    act_nxt = act_r;
    if (cmd.rearm) begin
      act_nxt = ARM;
    end else if (cmd.text) begin
      act_nxt = (hit & star_r) | fwd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= ARM;
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_token && count == MY_POS) begin
      char_r <= cmd.data;
      star_r <= 1'b0;
    end else if (cmd.add_star && count == MY_NEXT) begin
      star_r <= 1'b1;
    end
  end

endmodule

>>> src/wildcard_star_regex_matcher.sv
`timescale 1ns / 1ps
// Whole-string matcher for '.' and postfix '*' patterns, as a row of token cells.
// The match result is in out_tvalid in the cycle after the finish request. One
// request per cycle while in_tready is high; the cycle is set by the star
// closure rippling along the cell row. Reset (synchronous, rst_n low): empty
// pattern, flag clear, position zero active; no clearing pass, the block accepts
// requests at once. Depends on wsm_pkg and wsm_cell.
module wildcard_star_regex_matcher #(
  parameter int MAX_TOKENS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] matched, [1] pattern_overflow, [7:2] zero
);

  localparam int CNT_W = $clog2(MAX_TOKENS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOKENS);

  wsm_pkg::action_t act_in;
  wsm_pkg::cmd_t    cmd;
  logic             accept;
  logic             is_star;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             tail_r, tail_nxt;
  logic             out_valid_r;
  logic [1:0]       out_bits_r;

  logic [MAX_TOKENS-1:0] carry;
  logic [MAX_TOKENS-1:0] fwd;
  logic [MAX_TOKENS:0]   closed_vec;
  logic                  matched;

  assign act_in    = wsm_pkg::action_t'(in_tuser);
  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;
  assign is_star   = in_tdata == wsm_pkg::STAR_BYTE;

  always_comb begin
    cmd           = '0;
    cmd.data      = in_tdata;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    if (accept) begin
      unique case (act_in)
        wsm_pkg::ACT_CLEAR: begin
          cmd.rearm = 1'b1;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
        wsm_pkg::ACT_APPEND: begin
          cmd.rearm = 1'b1;
          if (is_star) begin
            cmd.add_star = 1'b1;
          end else if (count_r < CNT_MAX) begin
            cmd.add_token = 1'b1;
            count_nxt     = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        wsm_pkg::ACT_TEXT: begin
          cmd.text = 1'b1;
        end
        wsm_pkg::ACT_FINISH: begin
          cmd.rearm = 1'b1;
        end
        default: begin
          cmd.rearm = 1'b0;
        end
      endcase
    end
  end

  for (genvar j = 0; j < MAX_TOKENS; j++) begin : g_cell
    logic c_in, f_in;
    if (j == 0) begin : g_head
      assign c_in = 1'b0;
      assign f_in = 1'b0;
    end else begin : g_body
      assign c_in = carry[j-1];
      assign f_in = fwd[j-1];
    end
    wsm_cell #(
      .IDX   (j),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .count     (count_r),
      .carry_in  (c_in),
      .fwd_in    (f_in),
      .carry_out (carry[j]),
      .fwd_out   (fwd[j]),
      .closed    (closed_vec[j])
    );
  end

  // Position past the last token: pattern fully consumed.
  assign closed_vec[MAX_TOKENS] = tail_r | carry[MAX_TOKENS-1];
  assign matched                = closed_vec[count_r];

  always_comb begin
    tail_nxt = tail_r;
    if (cmd.rearm) begin
      tail_nxt = 1'b0;
    end else if (cmd.text) begin
      tail_nxt = fwd[MAX_TOKENS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      tail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      tail_r  <= tail_nxt;
      if (accept && act_in == wsm_pkg::ACT_FINISH) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && act_in == wsm_pkg::ACT_FINISH) begin
      out_bits_r <= {ovf_r, matched};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_bits_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("token count beyond capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == CNT_MAX)
    else $error("overflow flag with room left");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && act_in == wsm_pkg::ACT_FINISH) |=> out_valid_r)
    else $error("finish request gave no result");

  a_clear_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && act_in == wsm_pkg::ACT_CLEAR) |=>
      (count_r == '0 && !ovf_r && !tail_r && closed_vec[0]))
    else $error("clear did not empty pattern and re-arm");

endmodule
